FILE: sv/cpfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_pkg
// Shared constants, types and saturation helper for the cascaded PI
// power-factor controller.
// ----------------------------------------------------------------------------
package cpfc_pkg;

    localparam int WIN_LEN    = 12;
    localparam int CODE_W     = 12;
    localparam int POS_W      = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int SUM_W      = $clog2(WIN_LEN * ((1 << CODE_W) - 1) + 1);

    localparam int VAL_W      = 32;
    localparam int GAIN_W     = 31;
    localparam int SCALE_W    = 24;
    localparam int DUTY_W     = 23;
    localparam int REF_W      = 31;
    localparam int MUL_A_W    = VAL_W + 2;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SCALE_SHIFT = 8;
    localparam int GAIN_SHIFT  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic signed [VAL_W-1:0] DUTY_FULL = 32'sd6553600;

    localparam logic [SCALE_W-1:0] RST_VOLTAGE_SCALE = 24'd136568;
    localparam logic [SCALE_W-1:0] RST_CURRENT_SCALE = 24'd4268;
    localparam logic [GAIN_W-1:0]  RST_VOLTAGE_TARGET = 31'd26214400;
    localparam logic [GAIN_W-1:0]  RST_CURRENT_LIMIT  = 31'd819200;
    localparam logic [GAIN_W-1:0]  RST_VOLTAGE_KP     = 31'd1677722;
    localparam logic [GAIN_W-1:0]  RST_VOLTAGE_KI     = 31'd419;
    localparam logic [GAIN_W-1:0]  RST_CURRENT_KP     = 31'd3355443;
    localparam logic [GAIN_W-1:0]  RST_CURRENT_KI     = 31'd168;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLTAGE_SCALE,
        CFG_CURRENT_SCALE,
        CFG_VOLTAGE_TARGET,
        CFG_CURRENT_LIMIT,
        CFG_VOLTAGE_KP,
        CFG_VOLTAGE_KI,
        CFG_CURRENT_KP,
        CFG_CURRENT_KI
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SCALE_V,
        OP_SCALE_I,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_ADD_I,
        OP_BACK,
        OP_OUT,
        OP_LOAD
    } t_op;

    // loop: 0 outer voltage loop, 1 inner current loop
    typedef struct packed {
        t_op  op;
        logic loop;
    } t_cmd;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-VAL_W:0] top;
        top = v[PROD_W-1:VAL_W-1];
        if (top == '0 || top == '1) begin
            return v[VAL_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: sv/cpfc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_in_if
// Sample channel: one voltage code and one current code per beat.
// ----------------------------------------------------------------------------
interface cpfc_in_if import cpfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] bus_voltage_code;
    logic [CODE_W-1:0] bus_current_code;

    modport source (output valid, output bus_voltage_code, output bus_current_code,
                    input ready);
    modport sink   (input valid, input bus_voltage_code, input bus_current_code,
                    output ready);
endinterface

FILE: sv/cpfc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_out_if
// Result channel: duty pair and current reference per beat.
// ----------------------------------------------------------------------------
interface cpfc_out_if import cpfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_high;
    logic [DUTY_W-1:0] duty_low;
    logic [REF_W-1:0]  current_reference;

    modport source (output valid, output duty_high, output duty_low,
                    output current_reference, input ready);
    modport sink   (input valid, input duty_high, input duty_low,
                    input current_reference, output ready);
endinterface

FILE: sv/cpfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_ctrl
// Sequencer: steps the datapath through scaling and both PI loops and
// owns the channel handshakes.
// ----------------------------------------------------------------------------
module cpfc_ctrl import cpfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE_V,
        S_SCALE_I,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_ADD_I,
        S_BACK,
        S_OUT,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_loop;
    logic   r_out_valid;
    logic   load_ok;

    assign load_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.loop = r_loop;
        case (r_state)
            S_IDLE:    o_cmd.op = i_in_valid ? OP_ACCEPT : OP_NONE;
            S_SCALE_V: o_cmd.op = OP_SCALE_V;
            S_SCALE_I: o_cmd.op = OP_SCALE_I;
            S_ERR:     o_cmd.op = OP_ERR;
            S_MUL_P:   o_cmd.op = OP_MUL_P;
            S_MUL_I:   o_cmd.op = OP_MUL_I;
            S_ADD_I:   o_cmd.op = OP_ADD_I;
            S_BACK:    o_cmd.op = OP_BACK;
            S_OUT:     o_cmd.op = OP_OUT;
            S_HOLD:    o_cmd.op = load_ok ? OP_LOAD : OP_NONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result beat is loaded when the register is empty or its beat is taken at this edge
            if (r_state == S_HOLD && load_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCALE_V;
                    end
                end
                S_SCALE_V: r_state <= S_SCALE_I;
                S_SCALE_I: begin
                    r_loop  <= 1'b0;
                    r_state <= S_ERR;
                end
                S_ERR:   r_state <= S_MUL_P;
                S_MUL_P: r_state <= S_MUL_I;
                S_MUL_I: r_state <= S_ADD_I;
                S_ADD_I: r_state <= S_BACK;
                S_BACK:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_loop) begin
                        r_loop  <= 1'b1;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (load_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/cpfc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_dp
// Datapath: config registers, averaging windows, one shared multiplier and
// the add/compare logic of the two PI loops.
// ----------------------------------------------------------------------------
module cpfc_dp import cpfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [CODE_W-1:0]     i_voltage_code,
    input  logic [CODE_W-1:0]     i_current_code,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [DUTY_W-1:0]     o_duty_high,
    output logic [DUTY_W-1:0]     o_duty_low,
    output logic [REF_W-1:0]      o_current_reference
);

    // configuration
    logic [SCALE_W-1:0] r_vscale, r_iscale;
    logic [GAIN_W-1:0]  r_vtarget, r_ilimit;
    logic [GAIN_W-1:0]  r_kp [2];
    logic [GAIN_W-1:0]  r_ki [2];

    // windows
    logic [CODE_W-1:0] r_vwin [WIN_LEN];
    logic [CODE_W-1:0] r_iwin [WIN_LEN];
    logic [POS_W-1:0]  r_pos;
    logic [SUM_W-1:0]  r_vsum, r_isum;

    // loop state
    logic signed [VAL_W-1:0] r_last_err [2];
    logic signed [VAL_W-1:0] r_integ [2];

    // working registers
    logic signed [VAL_W-1:0] r_volts, r_amps, r_err, r_p, r_t, r_iraw, r_iref, r_duty;

    logic [DUTY_W-1:0] r_duty_high, r_duty_low;
    logic [REF_W-1:0]  r_ref_out;

    logic                      sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod, prod_sh;
    logic signed [VAL_W-1:0]   mul_res;
    logic signed [VAL_W-1:0]   ref_val, meas_val, limit;
    logic signed [VAL_W:0]     err_diff, integ_sum, pi_sum, lim_minus_p, neg_p, out_sum;
    logic signed [VAL_W-1:0]   integ_new, loop_out;

    assign sel = i_cmd.loop;

    always_comb begin
        case (i_cmd.op)
            OP_SCALE_V: begin
                mul_a = MUL_A_W'(r_vsum);
                mul_b = MUL_B_W'(r_vscale);
            end
            OP_SCALE_I: begin
                mul_a = MUL_A_W'(r_isum);
                mul_b = MUL_B_W'(r_iscale);
            end
            OP_MUL_I: begin
                mul_a = MUL_A_W'(r_err) + MUL_A_W'(r_last_err[sel]);
                mul_b = MUL_B_W'(r_ki[sel]);
            end
            default: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_kp[sel]);
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    // arithmetic shift gives floor rounding for negative products
    assign prod_sh = (i_cmd.op == OP_SCALE_V || i_cmd.op == OP_SCALE_I)
                     ? (prod >>> SCALE_SHIFT) : (prod >>> GAIN_SHIFT);
    assign mul_res = sat32(prod_sh);

    assign ref_val  = sel ? r_iref : VAL_W'(r_vtarget);
    assign meas_val = sel ? r_amps : r_volts;
    assign limit    = sel ? DUTY_FULL : VAL_W'(r_ilimit);

    assign err_diff    = (VAL_W+1)'(ref_val) - (VAL_W+1)'(meas_val);
    assign integ_sum   = (VAL_W+1)'(r_integ[sel]) + (VAL_W+1)'(r_t);
    assign pi_sum      = (VAL_W+1)'(r_p) + (VAL_W+1)'(r_iraw);
    assign lim_minus_p = (VAL_W+1)'(limit) - (VAL_W+1)'(r_p);
    assign neg_p       = '0 - (VAL_W+1)'(r_p);
    assign out_sum     = (VAL_W+1)'(r_p) + (VAL_W+1)'(r_integ[sel]);

    // back-calculation keeps p + i inside 0..limit
    always_comb begin
        if (pi_sum > (VAL_W+1)'(limit)) begin
            integ_new = sat32(PROD_W'(lim_minus_p));
        end else if (pi_sum < 0) begin
            integ_new = sat32(PROD_W'(neg_p));
        end else begin
            integ_new = r_iraw;
        end
    end

    always_comb begin
        if (out_sum > (VAL_W+1)'(limit)) begin
            loop_out = limit;
        end else if (out_sum < 0) begin
            loop_out = '0;
        end else begin
            loop_out = out_sum[VAL_W-1:0];
        end
    end

    // control-visible state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vscale      <= RST_VOLTAGE_SCALE;
            r_iscale      <= RST_CURRENT_SCALE;
            r_vtarget     <= RST_VOLTAGE_TARGET;
            r_ilimit      <= RST_CURRENT_LIMIT;
            r_kp[0]       <= RST_VOLTAGE_KP;
            r_ki[0]       <= RST_VOLTAGE_KI;
            r_kp[1]       <= RST_CURRENT_KP;
            r_ki[1]       <= RST_CURRENT_KI;
            for (int k = 0; k < WIN_LEN; k++) begin
                r_vwin[k] <= '0;
                r_iwin[k] <= '0;
            end
            r_pos         <= '0;
            r_vsum        <= '0;
            r_isum        <= '0;
            r_last_err[0] <= '0;
            r_last_err[1] <= '0;
            r_integ[0]    <= '0;
            r_integ[1]    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_VOLTAGE_SCALE:  r_vscale  <= i_cfg_data[SCALE_W-1:0];
                    CFG_CURRENT_SCALE:  r_iscale  <= i_cfg_data[SCALE_W-1:0];
                    CFG_VOLTAGE_TARGET: r_vtarget <= i_cfg_data[GAIN_W-1:0];
                    CFG_CURRENT_LIMIT:  r_ilimit  <= i_cfg_data[GAIN_W-1:0];
                    CFG_VOLTAGE_KP:     r_kp[0]   <= i_cfg_data[GAIN_W-1:0];
                    CFG_VOLTAGE_KI:     r_ki[0]   <= i_cfg_data[GAIN_W-1:0];
                    CFG_CURRENT_KP:     r_kp[1]   <= i_cfg_data[GAIN_W-1:0];
                    CFG_CURRENT_KI:     r_ki[1]   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    // running sums: drop the oldest entry, add the new code
                    r_vwin[r_pos] <= i_voltage_code;
                    r_iwin[r_pos] <= i_current_code;
                    r_vsum <= r_vsum - SUM_W'(r_vwin[r_pos]) + SUM_W'(i_voltage_code);
                    r_isum <= r_isum - SUM_W'(r_iwin[r_pos]) + SUM_W'(i_current_code);
                    r_pos  <= (r_pos == POS_W'(WIN_LEN - 1)) ? '0 : r_pos + 1'b1;
                end
                OP_BACK: begin
                    r_integ[sel]    <= integ_new;
                    r_last_err[sel] <= r_err;
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SCALE_V: r_volts <= mul_res;
            OP_SCALE_I: r_amps  <= mul_res;
            OP_ERR:     r_err   <= sat32(PROD_W'(err_diff));
            OP_MUL_P:   r_p     <= mul_res;
            OP_MUL_I:   r_t     <= mul_res;
            OP_ADD_I:   r_iraw  <= sat32(PROD_W'(integ_sum));
            OP_OUT: begin
                if (sel) begin
                    r_duty <= loop_out;
                end else begin
                    r_iref <= loop_out;
                end
            end
            OP_LOAD: begin
                r_duty_high <= r_duty[DUTY_W-1:0];
                r_duty_low  <= DUTY_FULL[DUTY_W-1:0] - r_duty[DUTY_W-1:0];
                r_ref_out   <= r_iref[REF_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_duty_high         = r_duty_high;
    assign o_duty_low          = r_duty_low;
    assign o_current_reference = r_ref_out;

endmodule

FILE: sv/cascaded_pi_pfc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pi_pfc_controller
// Cascaded PI controller: moving-average voltage/current sensing, outer
// voltage loop giving a current reference, inner current loop giving duty.
// ----------------------------------------------------------------------------
// Each accepted sample beat updates two 12-entry moving-average windows
// (running sums), scales them to Q16.16 volts and amps, then runs the outer
// voltage PI and the inner current PI, both trapezoidal with back-calculated
// integrators. One shared 34x32 multiplier and a six-step PI sequence run
// twice set the timing: after acceptance the core scales voltage and current,
// runs both PI sequences and loads the result beat, and only then takes the
// next sample. The result sits in an output register, so a new sample is
// accepted while the previous result still waits; the next result is held
// back only if that register is still full when it is ready. Configuration
// writes take effect at once and belong between samples.
module cascaded_pi_pfc_controller import cpfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpfc_in_if.sink               i_sample,
    cpfc_out_if.source            o_result,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    cpfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    cpfc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_voltage_code      (i_sample.bus_voltage_code),
        .i_current_code      (i_sample.bus_current_code),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_duty_high         (o_result.duty_high),
        .o_duty_low          (o_result.duty_low),
        .o_current_reference (o_result.current_reference)
    );

endmodule

FILE: test/tb_cascaded_pi_pfc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascaded_pi_pfc_controller
// Self-checking bench for the cascaded PI power-factor controller. Sample
// beats go in with random gaps, result beats come out with random back
// pressure. A bit-accurate model of the two moving windows and both PI loops
// predicts every result, which is compared field by field. Register settings
// cover reset values, saturating extremes, zero limit, all zero and random.
// ----------------------------------------------------------------------------
module tb_cascaded_pi_pfc_controller;
    import cpfc_pkg::*;

    localparam int                    STALL_LIMIT  = 2000;
    localparam int                    RAND_PHASES  = 8;
    localparam int                    PHASE_ITEMS  = 116;
    localparam int                    N_DIRECTED   = 22;
    localparam logic [CFG_DATA_W-1:0] MAX31        = 31'h7FFF_FFFF;
    localparam longint                INT32_MAX_L  = 64'sd2147483647;
    localparam longint                INT32_MIN_L  = -64'sd2147483648;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_high;
        logic [DUTY_W-1:0] duty_low;
        logic [REF_W-1:0]  current_reference;
    } t_duty_beat;

    typedef struct packed {
        logic [2:0]        setting;
        logic [CODE_W-1:0] v_code;
        logic [CODE_W-1:0] i_code;
        logic              typed;
        t_duty_beat        want;
    } t_sample_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cpfc_in_if  smp_if ();
    cpfc_out_if res_if ();

    cascaded_pi_pfc_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (smp_if),
        .o_result    (res_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register settings, in register index order
    logic [CFG_DATA_W-1:0] settings_tbl [5][8] = '{
        '{RST_VOLTAGE_SCALE, RST_CURRENT_SCALE, RST_VOLTAGE_TARGET, RST_CURRENT_LIMIT,
          RST_VOLTAGE_KP, RST_VOLTAGE_KI, RST_CURRENT_KP, RST_CURRENT_KI},
        '{MAX31, MAX31, MAX31, MAX31, MAX31, MAX31, MAX31, MAX31},
        '{MAX31, MAX31, 31'd0, MAX31, MAX31, MAX31, MAX31, MAX31},
        '{RST_VOLTAGE_SCALE, RST_CURRENT_SCALE, RST_VOLTAGE_TARGET, 31'd0,
          RST_VOLTAGE_KP, RST_VOLTAGE_KI, RST_CURRENT_KP, RST_CURRENT_KI},
        '{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0}
    };

    // first row after reset: empty windows, reference pinned at the limit
    t_sample_row directed_rows [N_DIRECTED] = '{
        '{3'd0, 12'd0,     12'd0,     1'b1, '{23'd163847, 23'd6389753, 31'd819200}},
        '{3'd0, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd0, 12'd0,     12'd4095,  1'b0, '0},
        '{3'd0, 12'd4095,  12'd0,     1'b0, '0},
        '{3'd0, 12'hAAA,   12'h555,   1'b0, '0},
        '{3'd0, 12'h555,   12'hAAA,   1'b0, '0},
        '{3'd0, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd0, 12'd2048,  12'd2048,  1'b0, '0},
        '{3'd1, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd1, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd1, 12'd0,     12'd0,     1'b0, '0},
        '{3'd1, 12'd4095,  12'd0,     1'b0, '0},
        '{3'd2, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd2, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd2, 12'd0,     12'd0,     1'b0, '0},
        '{3'd2, 12'd0,     12'd4095,  1'b0, '0},
        '{3'd3, 12'd3000,  12'd1000,  1'b0, '0},
        '{3'd3, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd3, 12'd0,     12'd0,     1'b0, '0},
        '{3'd4, 12'd4095,  12'd4095,  1'b0, '0},
        '{3'd4, 12'd0,     12'd0,     1'b0, '0},
        '{3'd4, 12'hAAA,   12'h555,   1'b0, '0}
    };

    // controller model state
    longint            cfg_reg [8];
    logic [CODE_W-1:0] v_win [WIN_LEN];
    logic [CODE_W-1:0] i_win [WIN_LEN];
    int                win_pos;
    int                v_last_err, v_integ, i_last_err, i_integ;

    t_duty_beat  pending_duty_q [$];
    int unsigned idle_pct = 15;
    int          fail_count = 0;
    int          samples_sent = 0;
    int          results_checked = 0;
    int          settings_applied = 0;
    int          stall_cycles = 0;

    function automatic int clip32(input longint x);
        if (x > INT32_MAX_L) return int'(INT32_MAX_L);
        if (x < INT32_MIN_L) return int'(INT32_MIN_L);
        return int'(x);
    endfunction

    // floor of (a * g) >> 24, saturated
    function automatic int gain_product(input longint a, input longint g);
        longint p;
        p = a * g;
        return clip32(p >>> GAIN_SHIFT);
    endfunction

    function automatic int scaled_measure(input longint sum, input longint scale);
        longint x;
        x = (sum * scale) >>> SCALE_SHIFT;
        return (x > INT32_MAX_L) ? int'(INT32_MAX_L) : int'(x);
    endfunction

    function automatic int pi_update(input int err, inout int last_err, inout int integ,
                                     input longint kp, input longint ki,
                                     input longint limit);
        int     p;
        int     i;
        longint s;
        longint o;
        p = gain_product(err, kp);
        i = clip32(longint'(integ) + gain_product(longint'(err) + last_err, ki));
        s = longint'(p) + i;
        last_err = err;
        // back-calculate the integrator so p + i sits inside 0..limit
        if (s > limit) i = clip32(limit - p);
        else if (s < 0) i = clip32(-longint'(p));
        integ = i;
        o = longint'(p) + i;
        if (o > limit) o = limit;
        if (o < 0) o = 0;
        return int'(o);
    endfunction

    function automatic t_duty_beat predict_control_step(input logic [CODE_W-1:0] v,
                                                        input logic [CODE_W-1:0] c);
        t_duty_beat beat;
        longint     vsum;
        longint     isum;
        int         volts, amps, iref, duty, rest;
        v_win[win_pos] = v;
        i_win[win_pos] = c;
        win_pos = (win_pos + 1 >= WIN_LEN) ? 0 : win_pos + 1;
        vsum = 0;
        isum = 0;
        for (int k = 0; k < WIN_LEN; k++) begin
            vsum += longint'(v_win[k]);
            isum += longint'(i_win[k]);
        end
        volts = scaled_measure(vsum, cfg_reg[int'(CFG_VOLTAGE_SCALE)]);
        amps  = scaled_measure(isum, cfg_reg[int'(CFG_CURRENT_SCALE)]);
        iref = pi_update(clip32(cfg_reg[int'(CFG_VOLTAGE_TARGET)] - volts),
                         v_last_err, v_integ, cfg_reg[int'(CFG_VOLTAGE_KP)],
                         cfg_reg[int'(CFG_VOLTAGE_KI)], cfg_reg[int'(CFG_CURRENT_LIMIT)]);
        duty = pi_update(clip32(longint'(iref) - amps), i_last_err, i_integ,
                         cfg_reg[int'(CFG_CURRENT_KP)], cfg_reg[int'(CFG_CURRENT_KI)],
                         longint'(DUTY_FULL));
        rest = DUTY_FULL - duty;
        beat.duty_high         = duty[DUTY_W-1:0];
        beat.duty_low          = rest[DUTY_W-1:0];
        beat.current_reference = iref[REF_W-1:0];
        return beat;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input longint rst_val);
        case ($urandom_range(9))
            0:       return '0;
            1:       return MAX31;
            2, 3:    return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'((rst_val * $urandom_range(200, 50)) / 100);
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        // scale registers keep only their low 24 bits
        if (idx == CFG_VOLTAGE_SCALE || idx == CFG_CURRENT_SCALE)
            cfg_reg[int'(idx)] = longint'(data[SCALE_W-1:0]);
        else
            cfg_reg[int'(idx)] = longint'(data);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] vals [8]);
        for (int k = 0; k < 8; k++) write_reg(t_cfg_idx'(k), vals[k]);
        i_cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // hold off samples until every result is back and the core is idle
    task automatic quiesce();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_duty_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [CODE_W-1:0] v, input logic [CODE_W-1:0] c,
                               input logic typed, input t_duty_beat want);
        t_duty_beat beat;
        while ($urandom_range(99) < idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid            <= 1'b1;
        smp_if.bus_voltage_code <= v;
        smp_if.bus_current_code <= c;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        beat = predict_control_step(v, c);
        pending_duty_q.push_back(typed ? want : beat);
        samples_sent++;
    endtask

    task automatic check_result();
        t_duty_beat want;
        if (pending_duty_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
        end else begin
            want = pending_duty_q.pop_front();
            results_checked++;
            if (res_if.duty_high !== want.duty_high) begin
                $error("duty_high: expected %0d, got %0d", want.duty_high, res_if.duty_high);
                fail_count++;
            end
            if (res_if.duty_low !== want.duty_low) begin
                $error("duty_low: expected %0d, got %0d", want.duty_low, res_if.duty_low);
                fail_count++;
            end
            if (res_if.current_reference !== want.current_reference) begin
                $error("current_reference: expected %0d, got %0d",
                       want.current_reference, res_if.current_reference);
                fail_count++;
            end
        end
    endtask

    // result side: random back pressure
    initial begin
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (res_if.valid && res_if.ready) check_result();
            res_if.ready <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || i_cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                    cur_setting;
        int                    v_lvl, i_lvl;
        logic [CFG_DATA_W-1:0] rand_vals [8];
        logic [CODE_W-1:0]     v, c;

        i_rst_n                 <= 1'b0;
        smp_if.valid            <= 1'b0;
        smp_if.bus_voltage_code <= '0;
        smp_if.bus_current_code <= '0;
        i_cfg_wr_en             <= 1'b0;
        i_cfg_index             <= CFG_VOLTAGE_SCALE;
        i_cfg_data              <= '0;

        for (int k = 0; k < 8; k++) cfg_reg[k] = longint'(settings_tbl[0][k]);
        for (int k = 0; k < WIN_LEN; k++) begin
            v_win[k] = '0;
            i_win[k] = '0;
        end
        win_pos    = 0;
        v_last_err = 0;
        v_integ    = 0;
        i_last_err = 0;
        i_integ    = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, starting from the reset setting
        cur_setting = 0;
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (int'(directed_rows[r].setting) != cur_setting) begin
                cur_setting = int'(directed_rows[r].setting);
                quiesce();
                apply_setting(settings_tbl[cur_setting]);
            end
            send_sample(directed_rows[r].v_code, directed_rows[r].i_code,
                        directed_rows[r].typed, directed_rows[r].want);
        end

        // random phases: mostly slow drift around an operating point, some noise
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiesce();
            if (ph == 0) begin
                apply_setting(settings_tbl[0]);
            end else begin
                for (int k = 0; k < 8; k++)
                    rand_vals[k] = pick_reg_value(longint'(settings_tbl[0][k]));
                apply_setting(rand_vals);
            end
            idle_pct = (ph == 1) ? 0 : 15;
            v_lvl = (ph < 3) ? int'($urandom_range(4095, 3600)) : int'($urandom_range(4095));
            i_lvl = int'($urandom_range(4095));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) quiesce();
                if ($urandom_range(99) < 80) begin
                    v_lvl = v_lvl + int'($urandom_range(80)) - 40;
                    i_lvl = i_lvl + int'($urandom_range(120)) - 60;
                    if (v_lvl < 0) v_lvl = 0;
                    if (v_lvl > 4095) v_lvl = 4095;
                    if (i_lvl < 0) i_lvl = 0;
                    if (i_lvl > 4095) i_lvl = 4095;
                    v = CODE_W'(v_lvl);
                    c = CODE_W'(i_lvl);
                end else begin
                    v = CODE_W'($urandom());
                    c = CODE_W'($urandom());
                end
                send_sample(v, c, 1'b0, '0);
            end
        end

        idle_pct = 15;
        quiesce();
        repeat (24) @(posedge i_clk);

        $display("covered %0d samples and %0d checked results over %0d register settings,",
                 samples_sent, results_checked, settings_applied + 1);
        $display("including saturating gains, zero current limit and all-zero registers");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
